/* rtl/srecord_line_parser_macros.svh */
// Assertion macros for the S-record parser, used by slp_back.
`ifndef SRECORD_LINE_PARSER_MACROS_SVH
`define SRECORD_LINE_PARSER_MACROS_SVH

// Checked only while out of reset.
`define SLP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked at every clock edge, reset included.
`define SLP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/slp_pkg.sv */
// Types, constants and helpers for the S-record line parser.
package slp_pkg;

  localparam logic [7:0] CH_S  = 8'h53;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] SUM_OK = 8'hFF;
  localparam logic [1:0] OQ_DEPTH = 2'd2;
  localparam logic [1:0] TQ_DEPTH = 2'd2;

  typedef enum logic [1:0] {
    K_DATA   = 2'd0,
    K_COMMIT = 2'd1,
    K_DONE   = 2'd2,
    K_ERROR  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    E_START = 3'd0,
    E_TYPE  = 3'd1,
    E_HEX   = 3'd2,
    E_LEN   = 3'd3,
    E_COUNT = 3'd4,
    E_SUM   = 3'd5,
    E_TRUNC = 3'd6
  } err_e;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_TYPE = 5'b00010,
    PH_HEX  = 5'b00100,
    PH_DONE = 5'b01000,
    PH_FAIL = 5'b10000
  } phase_e;

  // Classified character passed from the front end to the parser.
  typedef struct packed {
    logic       eoi;
    logic       eol;
    logic       is_s;
    logic       is_dec;
    logic       is_hex;
    logic [3:0] nib;
  } tok_t;

  typedef struct packed {
    kind_e       kind;
    logic [31:0] addr;
    logic [7:0]  data;
    err_e        code;
  } res_t;

  // Address bytes carried by S1, S2 and S3; none for other types.
  function automatic logic [2:0] addr_bytes_of(input logic [3:0] rtype);
    logic [2:0] al;
    case (rtype)
      4'd1:    al = 3'd2;
      4'd2:    al = 3'd3;
      4'd3:    al = 3'd4;
      default: al = 3'd0;
    endcase
    return al;
  endfunction

endpackage

/* rtl/slp_front.sv */
// Character classifier and two-entry token queue.
module slp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push,
  output logic              full,
  input  logic              cmd_i,
  input  logic [7:0]        char_code_i,
  output logic              tok_valid_o,
  output slp_pkg::tok_t     tok_o,
  input  logic              tok_pop_i
);

  slp_pkg::tok_t tok_in;
  slp_pkg::tok_t mem_q [2];
  logic          wr_q, rd_q;
  logic [1:0]    cnt_q;
  logic          wr_en, rd_en;

  always_comb begin
    tok_in        = '0;
    tok_in.eoi    = cmd_i;
    tok_in.eol    = !cmd_i && (char_code_i == slp_pkg::CH_LF ||
                               char_code_i == slp_pkg::CH_CR);
    tok_in.is_s   = !cmd_i && (char_code_i == slp_pkg::CH_S);
    tok_in.is_dec = !cmd_i && (char_code_i inside {[8'h30:8'h39]});
    tok_in.is_hex = tok_in.is_dec ||
                    (!cmd_i && (char_code_i inside {[8'h41:8'h46], [8'h61:8'h66]}));
    if (tok_in.is_dec) begin
      tok_in.nib = char_code_i[3:0];
    end else begin
      tok_in.nib = char_code_i[3:0] + 4'd9;
    end
  end

  assign full        = (cnt_q == slp_pkg::TQ_DEPTH);
  assign tok_valid_o = (cnt_q != 2'd0);
  assign tok_o       = mem_q[rd_q];
  assign wr_en       = push && !full;
  assign rd_en       = tok_pop_i && tok_valid_o;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= tok_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (wr_en) wr_q <= !wr_q;
      if (rd_en) rd_q <= !rd_q;
      if (wr_en && !rd_en) begin
        cnt_q <= cnt_q + 2'd1;
      end else if (rd_en && !wr_en) begin
        cnt_q <= cnt_q - 2'd1;
      end
    end
  end

endmodule

/* rtl/slp_back.sv */
// Record parser state machine with two-entry result queue.
`include "srecord_line_parser_macros.svh"

module slp_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [31:0]       cfg_wdata_i,
  input  logic              tok_valid_i,
  input  slp_pkg::tok_t     tok_i,
  output logic              tok_pop_o,
  output logic              empty,
  input  logic              pop,
  output slp_pkg::res_t     res_o
);

  slp_pkg::phase_e phase_q, phase_d;
  logic [3:0]  rtype_q, rtype_d;
  logic [3:0]  hi_q, hi_d;
  logic        pend_q, pend_d;
  logic [8:0]  idx_q, idx_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  sum_q, sum_d;
  logic [31:0] raddr_q, raddr_d;
  logic [31:0] base_q, base_d;
  logic [7:0]  held_q, held_d;
  logic        hvalid_q, hvalid_d;
  logic [31:0] offset_q;

  slp_pkg::res_t omem_q [2];
  logic          owr_q, ord_q;
  logic [1:0]    ocnt_q;
  logic          opush, opop;

  slp_pkg::res_t res;
  logic          take;
  logic [7:0]    b;
  logic [2:0]    al;

  assign take      = tok_valid_i && (ocnt_q != slp_pkg::OQ_DEPTH);
  assign tok_pop_o = take;
  assign b         = {hi_q, tok_i.nib};
  assign al        = slp_pkg::addr_bytes_of(rtype_q);

  always_comb begin
    phase_d  = phase_q;
    rtype_d  = rtype_q;
    hi_d     = hi_q;
    pend_d   = pend_q;
    idx_d    = idx_q;
    count_d  = count_q;
    sum_d    = sum_q;
    raddr_d  = raddr_q;
    base_d   = base_q;
    held_d   = held_q;
    hvalid_d = hvalid_q;
    opush    = 1'b0;
    res      = '{kind: slp_pkg::K_DATA, addr: 32'd0, data: 8'd0, code: slp_pkg::E_START};
    if (take) begin
      case (phase_q)
        slp_pkg::PH_IDLE: begin
          if (tok_i.eoi) begin
            phase_d  = slp_pkg::PH_DONE;
            opush    = 1'b1;
            res.kind = slp_pkg::K_DONE;
          end else if (tok_i.eol) begin
            phase_d = slp_pkg::PH_IDLE;
          end else if (!tok_i.is_s) begin
            phase_d  = slp_pkg::PH_FAIL;
            opush    = 1'b1;
            res.kind = slp_pkg::K_ERROR;
            res.code = slp_pkg::E_START;
          end else begin
            phase_d  = slp_pkg::PH_TYPE;
            rtype_d  = 4'd0;
            hi_d     = 4'd0;
            pend_d   = 1'b0;
            idx_d    = 9'd0;
            count_d  = 8'd0;
            sum_d    = 8'd0;
            raddr_d  = 32'd0;
            held_d   = 8'd0;
            hvalid_d = 1'b0;
          end
        end
        slp_pkg::PH_TYPE: begin
          if (tok_i.eoi || tok_i.eol || !tok_i.is_dec) begin
            phase_d  = slp_pkg::PH_FAIL;
            opush    = 1'b1;
            res.kind = slp_pkg::K_ERROR;
            res.code = tok_i.eoi ? slp_pkg::E_TRUNC :
                       tok_i.eol ? slp_pkg::E_LEN : slp_pkg::E_TYPE;
          end else begin
            rtype_d = tok_i.nib;
            phase_d = slp_pkg::PH_HEX;
          end
        end
        slp_pkg::PH_HEX: begin
          if (tok_i.eoi) begin
            phase_d  = slp_pkg::PH_FAIL;
            opush    = 1'b1;
            res.kind = slp_pkg::K_ERROR;
            res.code = slp_pkg::E_TRUNC;
          end else if (tok_i.eol) begin
            opush    = 1'b1;
            res.kind = slp_pkg::K_ERROR;
            phase_d  = slp_pkg::PH_FAIL;
            if (pend_q || idx_q < 9'd4) begin
              res.code = slp_pkg::E_LEN;
            end else if ({1'b0, count_q} + 9'd1 != idx_q) begin
              res.code = slp_pkg::E_COUNT;
            end else if (sum_q != slp_pkg::SUM_OK) begin
              res.code = slp_pkg::E_SUM;
            end else if (al != 3'd0 && count_q < {5'd0, al} + 8'd1) begin
              res.code = slp_pkg::E_COUNT;
            end else if (rtype_q >= 4'd7) begin
              phase_d  = slp_pkg::PH_DONE;
              res.kind = slp_pkg::K_DONE;
            end else begin
              phase_d  = slp_pkg::PH_IDLE;
              res.kind = slp_pkg::K_COMMIT;
              opush    = (al != 3'd0);
            end
          end else if (!tok_i.is_hex) begin
            phase_d  = slp_pkg::PH_FAIL;
            opush    = 1'b1;
            res.kind = slp_pkg::K_ERROR;
            res.code = slp_pkg::E_HEX;
          end else if (!pend_q) begin
            hi_d   = tok_i.nib;
            pend_d = 1'b1;
          end else if (idx_q[8]) begin
            pend_d   = 1'b0;
            phase_d  = slp_pkg::PH_FAIL;
            opush    = 1'b1;
            res.kind = slp_pkg::K_ERROR;
            res.code = slp_pkg::E_COUNT;
          end else begin
            pend_d = 1'b0;
            sum_d  = sum_q + b;
            idx_d  = idx_q + 9'd1;
            if (idx_q == 9'd0) begin
              count_d = b;
            end else if (al != 3'd0) begin
              if (idx_q <= {6'd0, al}) begin
                raddr_d = {raddr_q[23:0], b};
                if (idx_q == {6'd0, al}) begin
                  base_d = offset_q + {raddr_q[23:0], b};
                end
              end else begin
                if (hvalid_q) begin
                  opush    = 1'b1;
                  res.kind = slp_pkg::K_DATA;
                  res.addr = base_q;
                  res.data = held_q;
                  base_d   = base_q + 32'd1;
                end
                held_d   = b;
                hvalid_d = 1'b1;
              end
            end
          end
        end
        default: begin
          phase_d = phase_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= slp_pkg::PH_IDLE;
      rtype_q  <= 4'd0;
      hi_q     <= 4'd0;
      pend_q   <= 1'b0;
      idx_q    <= 9'd0;
      count_q  <= 8'd0;
      sum_q    <= 8'd0;
      raddr_q  <= 32'd0;
      base_q   <= 32'd0;
      held_q   <= 8'd0;
      hvalid_q <= 1'b0;
      offset_q <= 32'd0;
    end else begin
      phase_q  <= phase_d;
      rtype_q  <= rtype_d;
      hi_q     <= hi_d;
      pend_q   <= pend_d;
      idx_q    <= idx_d;
      count_q  <= count_d;
      sum_q    <= sum_d;
      raddr_q  <= raddr_d;
      base_q   <= base_d;
      held_q   <= held_d;
      hvalid_q <= hvalid_d;
      if (cfg_we_i) offset_q <= cfg_wdata_i;
    end
  end

  // Result queue
  assign empty = (ocnt_q == 2'd0);
  assign res_o = omem_q[ord_q];
  assign opop  = pop && !empty;

  always_ff @(posedge clk_i) begin
    if (opush) begin
      omem_q[owr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      owr_q  <= 1'b0;
      ord_q  <= 1'b0;
      ocnt_q <= 2'd0;
    end else begin
      if (opush) owr_q <= !owr_q;
      if (opop)  ord_q <= !ord_q;
      if (opush && !opop) begin
        ocnt_q <= ocnt_q + 2'd1;
      end else if (opop && !opush) begin
        ocnt_q <= ocnt_q - 2'd1;
      end
    end
  end

  `SLP_ASSERT(a_done_sticky, clk_i, rst_ni, (phase_q == slp_pkg::PH_DONE) |=> (phase_q == slp_pkg::PH_DONE), "done state left before reset")
  `SLP_ASSERT(a_err_fails, clk_i, rst_ni, (opush && res.kind == slp_pkg::K_ERROR) |=> (phase_q == slp_pkg::PH_FAIL), "error reported without entering fail state")
  `SLP_ASSERT(a_data_type, clk_i, rst_ni, (opush && res.kind == slp_pkg::K_DATA) |-> (rtype_q == 4'd1 || rtype_q == 4'd2 || rtype_q == 4'd3), "data item from a record without address")
  `SLP_ASSERT(a_oq_bound, clk_i, rst_ni, ocnt_q <= slp_pkg::OQ_DEPTH, "result queue overfilled")

endmodule

/* rtl/srecord_line_parser.sv */
// S-record line parser: top level joining the classifier and the record parser.
//
// Input channel: one item per character (cmd_i low, char_code_i) or an
// end-of-input mark (cmd_i high). An item is taken at a clock edge with push
// high and full low. Results leave through a queue: while empty is low the
// oldest result sits on kind_o, byte_address_o, data_byte_o and error_code_o,
// and pop at a clock edge takes it.
// The address offset register is written through cfg_we_i / cfg_wdata_i;
// the user writes it only while the block is idle; the block does not enforce it.
// A result caused by an item passes from the classifier queue through the parser
// into the result queue.
// Throughput: one item per cycle while the result queue has room; both
// sides are parted by two-entry queues.
// When pop is held low the result queue fills, the parser stops taking tokens
// and full rises once the token queue is full; nothing is dropped.
// Reset empties both queues, clears the offset to zero and returns the parser
// to waiting for a line start; after done or an error all input is discarded
// until the next reset.
module srecord_line_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        cmd_i,
  input  logic [7:0]  char_code_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  kind_o,
  output logic [31:0] byte_address_o,
  output logic [7:0]  data_byte_o,
  output logic [2:0]  error_code_o,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_wdata_i
);

  slp_pkg::tok_t tok;
  slp_pkg::res_t res;
  logic          tok_valid;
  logic          tok_pop;

  slp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .cmd_i       (cmd_i),
    .char_code_i (char_code_i),
    .tok_valid_o (tok_valid),
    .tok_o       (tok),
    .tok_pop_i   (tok_pop)
  );

  slp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .tok_valid_i (tok_valid),
    .tok_i       (tok),
    .tok_pop_o   (tok_pop),
    .empty       (empty),
    .pop         (pop),
    .res_o       (res)
  );

  assign kind_o         = res.kind;
  assign byte_address_o = res.addr;
  assign data_byte_o    = res.data;
  assign error_code_o   = res.code;

endmodule

/* tb/sv/testbench.sv */
// Testbench for srecord_line_parser: random S-record streams checked against a scoreboard.
module testbench;

  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int FILL_RANDOM = 0;
  localparam int FILL_ZEROS  = 1;
  localparam int FILL_ONES   = 2;
  localparam logic [7:0] CH_0 = "0";
  localparam logic [7:0] CH_9 = "9";

  class srec_scoreboard;
    logic [31:0]      offset;
    slp_pkg::phase_e  ph;
    logic [3:0]       rtype;
    logic [3:0]       hi_nib;
    bit               nib_pend;
    int unsigned      idx;
    logic [7:0]       count_b;
    logic [7:0]       sum_b;
    logic [31:0]      rec_addr;
    logic [7:0]       held_b;
    bit               held_v;
    slp_pkg::res_t    expected_q[$];
    int unsigned      errors;

    function new();
      offset   = '0;
      ph       = slp_pkg::PH_IDLE;
      rtype    = '0;
      hi_nib   = '0;
      nib_pend = 1'b0;
      idx      = 0;
      count_b  = '0;
      sum_b    = '0;
      rec_addr = '0;
      held_b   = '0;
      held_v   = 1'b0;
      errors   = 0;
    endfunction

    function int addr_bytes(logic [3:0] t);
      case (t)
        4'd1:    return 2;
        4'd2:    return 3;
        4'd3:    return 4;
        default: return 0;
      endcase
    endfunction

    function int nibble_of(logic [7:0] ch);
      if (ch >= "0" && ch <= "9") return int'(ch - "0");
      if (ch >= "A" && ch <= "F") return int'(ch - "A") + 10;
      if (ch >= "a" && ch <= "f") return int'(ch - "a") + 10;
      return -1;
    endfunction

    function void add_result(slp_pkg::kind_e k, logic [31:0] a, logic [7:0] d,
                             slp_pkg::err_e c);
      slp_pkg::res_t r;
      r.kind = k;
      r.addr = a;
      r.data = d;
      r.code = c;
      expected_q.push_back(r);
    endfunction

    function void raise_error(slp_pkg::err_e c);
      ph = slp_pkg::PH_FAIL;
      add_result(slp_pkg::K_ERROR, '0, '0, c);
    endfunction

    function void take_byte(logic [7:0] b);
      int al;
      logic [31:0] a;
      al = addr_bytes(rtype);
      if (idx >= 256) begin
        raise_error(slp_pkg::E_COUNT);
        return;
      end
      sum_b = sum_b + b;
      if (idx == 0) begin
        count_b = b;
      end else if (al != 0) begin
        if (idx <= al) begin
          rec_addr = {rec_addr[23:0], b};
        end else begin
          // data goes out one byte late so the checksum never does
          if (held_v) begin
            a = offset + rec_addr + 32'(idx - 2 - al);
            add_result(slp_pkg::K_DATA, a, held_b, slp_pkg::E_START);
          end
          held_b = b;
          held_v = 1'b1;
        end
      end
      idx++;
    endfunction

    function void end_line();
      int al;
      al = addr_bytes(rtype);
      if (nib_pend || idx < 4) raise_error(slp_pkg::E_LEN);
      else if (int'(count_b) + 1 != idx) raise_error(slp_pkg::E_COUNT);
      else if (sum_b != slp_pkg::SUM_OK) raise_error(slp_pkg::E_SUM);
      else if (al != 0 && int'(count_b) < al + 1) raise_error(slp_pkg::E_COUNT);
      else if (rtype >= 4'd7) begin
        ph = slp_pkg::PH_DONE;
        add_result(slp_pkg::K_DONE, '0, '0, slp_pkg::E_START);
      end else begin
        ph = slp_pkg::PH_IDLE;
        if (al != 0) add_result(slp_pkg::K_COMMIT, '0, '0, slp_pkg::E_START);
      end
    endfunction

    function void note_input(logic c, logic [7:0] ch);
      bit eol;
      int v;
      eol = (ch == slp_pkg::CH_LF) || (ch == slp_pkg::CH_CR);
      if (ph == slp_pkg::PH_DONE || ph == slp_pkg::PH_FAIL) return;
      if (c) begin
        if (ph == slp_pkg::PH_IDLE) begin
          ph = slp_pkg::PH_DONE;
          add_result(slp_pkg::K_DONE, '0, '0, slp_pkg::E_START);
        end else begin
          raise_error(slp_pkg::E_TRUNC);
        end
        return;
      end
      case (ph)
        slp_pkg::PH_IDLE: begin
          if (eol) return;
          if (ch != slp_pkg::CH_S) begin
            raise_error(slp_pkg::E_START);
          end else begin
            ph       = slp_pkg::PH_TYPE;
            rtype    = '0;
            hi_nib   = '0;
            nib_pend = 1'b0;
            idx      = 0;
            count_b  = '0;
            sum_b    = '0;
            rec_addr = '0;
            held_b   = '0;
            held_v   = 1'b0;
          end
        end
        slp_pkg::PH_TYPE: begin
          if (eol) raise_error(slp_pkg::E_LEN);
          else if (ch < CH_0 || ch > CH_9) raise_error(slp_pkg::E_TYPE);
          else begin
            rtype = 4'(ch - CH_0);
            ph    = slp_pkg::PH_HEX;
          end
        end
        default: begin
          if (eol) begin
            end_line();
          end else begin
            v = nibble_of(ch);
            if (v < 0) raise_error(slp_pkg::E_HEX);
            else if (!nib_pend) begin
              hi_nib   = 4'(v);
              nib_pend = 1'b1;
            end else begin
              nib_pend = 1'b0;
              take_byte({hi_nib, 4'(v)});
            end
          end
        end
      endcase
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      errors++;
      $display("MISMATCH %s: got %0h, want %0h", what, got, want);
    endtask

    task check_result(logic [1:0] k, logic [31:0] a, logic [7:0] d, logic [2:0] c);
      slp_pkg::res_t e;
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected result, kind", 32'(k), '0);
        return;
      end
      e = expected_q.pop_front();
      if (e.kind !== k) report_mismatch("kind", 32'(k), 32'(e.kind));
      if (e.addr !== a) report_mismatch("byte_address", a, e.addr);
      if (e.data !== d) report_mismatch("data_byte", 32'(d), 32'(e.data));
      if (e.code !== c) report_mismatch("error_code", 32'(c), 32'(e.code));
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        cmd_i = 1'b0;
  logic [7:0]  char_code_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [1:0]  kind_o;
  logic [31:0] byte_address_o;
  logic [7:0]  data_byte_o;
  logic [2:0]  error_code_o;
  logic        cfg_we_i = 1'b0;
  logic [31:0] cfg_wdata_i = '0;

  srec_scoreboard sb;
  int          snd_idle_pct = 12;
  int          rcv_idle_pct = 45;
  int          items_in_phase;
  int unsigned quiet_cycles = 0;
  logic [7:0]  line_chars[$];

  srecord_line_parser DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .cmd_i          (cmd_i),
    .char_code_i    (char_code_i),
    .empty          (empty),
    .pop            (pop),
    .kind_o         (kind_o),
    .byte_address_o (byte_address_o),
    .data_byte_o    (data_byte_o),
    .error_code_o   (error_code_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && push && !full) sb.note_input(cmd_i, char_code_i);
    if (rst_ni && pop && !empty) begin
      sb.check_result(kind_o, byte_address_o, data_byte_o, error_code_o);
    end
    pop <= ($urandom_range(0, 99) >= rcv_idle_pct);
    if ((push && !full) || (pop && !empty)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", QUIET_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic send_item(input logic c, input logic [7:0] ch);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push        <= 1'b1;
    cmd_i       <= c;
    char_code_i <= ch;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    items_in_phase++;
  endtask

  task automatic wait_for_results();
    push <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_offset(input logic [31:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.offset = v;
  endtask

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'(CH_0 + n);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + n - 4'd10);
  endfunction

  task automatic build_record(input int t, input int na, input int nd, input int count_adj,
                              input logic [7:0] sum_adj, input int fill);
    logic [7:0] bytes[$];
    logic [7:0] b;
    logic [7:0] sum;
    bytes.push_back(8'(1 + na + nd + count_adj));
    for (int i = 0; i < na + nd; i++) begin
      case (fill)
        FILL_ZEROS: b = 8'h00;
        FILL_ONES:  b = 8'hFF;
        default:    b = 8'($urandom);
      endcase
      bytes.push_back(b);
    end
    sum = '0;
    foreach (bytes[i]) sum = sum + bytes[i];
    bytes.push_back(slp_pkg::SUM_OK - sum + sum_adj);
    line_chars.delete();
    line_chars.push_back(slp_pkg::CH_S);
    line_chars.push_back(8'(CH_0 + t));
    foreach (bytes[i]) begin
      line_chars.push_back(hex_char(bytes[i][7:4]));
      line_chars.push_back(hex_char(bytes[i][3:0]));
    end
  endtask

  task automatic send_line();
    foreach (line_chars[i]) send_item(1'b0, line_chars[i]);
    case ($urandom_range(0, 3))
      0: send_item(1'b0, slp_pkg::CH_LF);
      1: begin
        send_item(1'b0, slp_pkg::CH_CR);
        send_item(1'b0, slp_pkg::CH_LF);
      end
      2: send_item(1'b0, slp_pkg::CH_CR);
      default: begin
        send_item(1'b0, slp_pkg::CH_LF);
        send_item(1'b0, slp_pkg::CH_LF);
      end
    endcase
  endtask

  task automatic random_record();
    int r;
    int t;
    int na;
    int nd;
    r = $urandom_range(0, 9);
    if (r < 3) t = 1;
    else if (r < 6) t = 2;
    else if (r < 8) t = 3;
    else t = (r == 8) ? 0 : $urandom_range(4, 6);
    case (t)
      1: na = 2;
      2: na = 3;
      3: na = 4;
      default: na = $urandom_range(0, 4);
    endcase
    nd = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 64) : $urandom_range(0, 8);
    if (na + nd < 2) nd = 2 - na;
    build_record(t, na, nd, 0, 8'h00, FILL_RANDOM);
    send_line();
    if ($urandom_range(0, 7) == 0) begin
      send_item(1'b0, $urandom_range(0, 1) ? slp_pkg::CH_CR : slp_pkg::CH_LF);
    end
  endtask

  // one closing event per run, since the block goes dead after done or an error
  task automatic end_of_file();
    logic [7:0] ch;
    int na;
    int cut;
    case ($urandom_range(0, 10))
      0: send_item(1'b1, 8'($urandom));
      1: begin
        na = $urandom_range(0, 4);
        build_record($urandom_range(7, 9), na, (na < 2) ? 2 - na : 0, 0, 8'h00, FILL_RANDOM);
        send_line();
      end
      2: begin
        do ch = 8'($urandom);
        while (ch == slp_pkg::CH_LF || ch == slp_pkg::CH_CR || ch == slp_pkg::CH_S);
        send_item(1'b0, ch);
      end
      3: begin
        do ch = 8'($urandom);
        while ((ch >= CH_0 && ch <= CH_9) || ch == slp_pkg::CH_LF || ch == slp_pkg::CH_CR);
        send_item(1'b0, slp_pkg::CH_S);
        send_item(1'b0, ch);
      end
      4: begin
        send_item(1'b0, slp_pkg::CH_S);
        send_item(1'b0, $urandom_range(0, 1) ? slp_pkg::CH_CR : slp_pkg::CH_LF);
      end
      5: begin
        do ch = 8'($urandom);
        while (sb.nibble_of(ch) >= 0 || ch == slp_pkg::CH_LF || ch == slp_pkg::CH_CR);
        build_record(1, 2, $urandom_range(0, 6), 0, 8'h00, FILL_RANDOM);
        line_chars.insert($urandom_range(2, line_chars.size()), ch);
        send_line();
      end
      6: begin
        if ($urandom_range(0, 1)) begin
          build_record(2, 3, $urandom_range(0, 6), 0, 8'h00, FILL_RANDOM);
          void'(line_chars.pop_back());
        end else begin
          build_record(5, 0, 1, 0, 8'h00, FILL_RANDOM);
        end
        send_line();
      end
      7: begin
        build_record(3, 4, $urandom_range(0, 6), $urandom_range(0, 1) ? 1 : -1, 8'h00,
                     FILL_RANDOM);
        send_line();
      end
      8: begin
        build_record(1, 2, $urandom_range(0, 6), 0, 8'($urandom_range(1, 255)), FILL_RANDOM);
        send_line();
      end
      9: begin
        if ($urandom_range(0, 1)) build_record(2, 2, 0, 0, 8'h00, FILL_RANDOM);
        else build_record(3, $urandom_range(2, 3), 0, 0, 8'h00, FILL_RANDOM);
        send_line();
      end
      default: begin
        build_record(1, 2, $urandom_range(0, 6), 0, 8'h00, FILL_RANDOM);
        cut = $urandom_range(1, line_chars.size());
        for (int i = 0; i < cut; i++) send_item(1'b0, line_chars[i]);
        send_item(1'b1, 8'($urandom));
      end
    endcase
    // ignored from here on
    send_item(1'b0, 8'hFF);
    send_item(1'b1, 8'h00);
    repeat (24) send_item(1'($urandom), 8'($urandom));
  endtask

  initial begin
    logic [31:0] offsets[3];
    sb = new();
    offsets[0] = 32'hFFFF_FFFF;
    offsets[1] = $urandom;
    offsets[2] = 32'h0000_0000;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // short directed stretch at the reset offset
    send_item(1'b0, slp_pkg::CH_LF);
    send_item(1'b0, slp_pkg::CH_CR);
    build_record(1, 2, 1, 0, 8'h00, FILL_ONES);
    send_line();
    build_record(5, 2, 0, 0, 8'h00, FILL_RANDOM);
    send_line();

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          snd_idle_pct = 12;
          rcv_idle_pct = 45;
        end
        1: begin
          snd_idle_pct = 45;
          rcv_idle_pct = 12;
        end
        default: begin
          snd_idle_pct = 0;
          rcv_idle_pct = 0;
        end
      endcase
      wait_for_results();
      write_offset(offsets[p]);
      items_in_phase = 0;
      while (items_in_phase < 110) random_record();
    end

    end_of_file();
    wait_for_results();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
